[src/bmsp_pkg.sv]
// Shared types and constants of the brace markup style parser.
package bmsp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned NumRegs = 4;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned PosOutW = 16;
  localparam int unsigned AccW    = 10;
  localparam int unsigned CntW    = 4;

  // register indexes
  localparam logic [1:0] REG_FACE  = 2'd0;
  localparam logic [1:0] REG_RED   = 2'd1;
  localparam logic [1:0] REG_GREEN = 2'd2;
  localparam logic [1:0] REG_BLUE  = 2'd3;

  // markup bytes
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_FACE   = 8'h66; // f
  localparam logic [7:0] CH_SKIP   = 8'h45; // E
  localparam logic [7:0] CH_COLOUR = 8'h49; // I
  localparam logic [7:0] CH_MOVE   = 8'h58; // X
  localparam logic [7:0] CH_LEFT   = 8'h47; // G
  localparam logic [7:0] CH_RIGHT  = 8'h44; // D
  localparam logic [7:0] CH_CENTER = 8'h43; // C
  localparam logic [7:0] CH_JUST   = 8'h46; // F
  localparam logic [7:0] CH_BLINK  = 8'h42; // B

  localparam logic [CntW-1:0] CntFirst  = CntW'(3);
  localparam logic [CntW-1:0] CntSecond = CntW'(6);
  localparam logic [CntW-1:0] CntLast   = CntW'(9);

  typedef enum logic [2:0] {
    PD_NONE,
    PD_FACE,
    PD_SKIP,
    PD_COLOUR,
    PD_MOVE
  } pend_e;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_MOVE,
    KIND_ALIGN
  } kind_e;

  typedef enum logic [1:0] {
    ALIGN_LEFT,
    ALIGN_RIGHT,
    ALIGN_CENTER,
    ALIGN_JUSTIFY
  } align_e;

  typedef struct packed {
    logic [7:0] face;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         glyph_code;
    logic [7:0]         face_letter;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               blinking;
    logic [PosOutW-1:0] run_position;
    logic [9:0]         x_percent;
    logic [9:0]         y_percent;
    align_e             align_code;
    logic               applies_to_move;
  } res_t;

endpackage

[src/bmsp_if.sv]
// Valid/ready channel interfaces for markup bytes and parser results.
interface bmsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_string;

  modport source (output valid, char_in, end_of_string, input ready);
  modport sink   (input valid, char_in, end_of_string, output ready);
endinterface

interface bmsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  glyph_code;
  logic [7:0]  face_letter;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        blinking;
  logic [15:0] run_position;
  logic [9:0]  x_percent;
  logic [9:0]  y_percent;
  logic [1:0]  align_code;
  logic        applies_to_move;

  modport source (output valid, kind, glyph_code, face_letter, red, green, blue, blinking,
                  run_position, x_percent, y_percent, align_code, applies_to_move,
                  input ready);
  modport sink   (input valid, kind, glyph_code, face_letter, red, green, blue, blinking,
                  run_position, x_percent, y_percent, align_code, applies_to_move,
                  output ready);
endinterface

[src/brace_markup_style_parser.sv]
// Top level of the brace markup style parser: channels, registers, buffering.
//
// Takes one markup byte per clock unless a waiting result stalls the input, and
// returns at most one result per byte (styled character, move record or
// alignment change), in byte order. A byte goes into an input register, is
// parsed by the parse state update, and its result lands in an output register.
// The input register can take one more byte while a result waits in the output
// register; after that the input stalls until the result drains. Register
// writes over the APB port take effect at the start of the next string.
module brace_markup_style_parser import bmsp_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bmsp_in_if.sink          char_i,
  bmsp_out_if.source       res_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg_q;
  logic [1:0] reg_idx;
  logic       cfg_wr;

  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       advance;

  logic       core_vld;
  res_t       core_res;
  logic       out_vld_q;
  res_t       out_q;

  // configuration registers
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.face  <= 8'd0;
      cfg_q.red   <= 8'd255;
      cfg_q.green <= 8'd255;
      cfg_q.blue  <= 8'd255;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FACE:  cfg_q.face  <= pwdata[7:0];
        REG_RED:   cfg_q.red   <= pwdata[7:0];
        REG_GREEN: cfg_q.green <= pwdata[7:0];
        REG_BLUE:  cfg_q.blue  <= pwdata[7:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FACE:  prdata = DataW'(cfg_q.face);
      REG_RED:   prdata = DataW'(cfg_q.red);
      REG_GREEN: prdata = DataW'(cfg_q.green);
      REG_BLUE:  prdata = DataW'(cfg_q.blue);
      default:   prdata = '0;
    endcase
  end

  // byte moves on when the output register is free or drains this cycle
  assign advance      = in_vld_q && (!out_vld_q || res_o.ready);
  assign char_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (char_i.ready) begin
      in_vld_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      in_char_q <= char_i.char_in;
      in_last_q <= char_i.end_of_string;
    end
  end

  bmsp_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .char_i     (in_char_q),
    .last_i     (in_last_q),
    .cfg_i      (cfg_q),
    .res_valid_o(core_vld),
    .res_o      (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= core_vld;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && core_vld) begin
      out_q <= core_res;
    end
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.kind            = out_q.kind;
  assign res_o.glyph_code      = out_q.glyph_code;
  assign res_o.face_letter     = out_q.face_letter;
  assign res_o.red             = out_q.red;
  assign res_o.green           = out_q.green;
  assign res_o.blue            = out_q.blue;
  assign res_o.blinking        = out_q.blinking;
  assign res_o.run_position    = out_q.run_position;
  assign res_o.x_percent       = out_q.x_percent;
  assign res_o.y_percent       = out_q.y_percent;
  assign res_o.align_code      = out_q.align_code;
  assign res_o.applies_to_move = out_q.applies_to_move;

endmodule

[src/bmsp_core.sv]
// Parse state and per-byte update of the markup parser.
module bmsp_core import bmsp_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam logic [POSITION_BITS-1:0] CountMax = {POSITION_BITS{1'b1}};

  logic                     inside_q, inside_d;
  pend_e                    pend_q, pend_d;
  logic [CntW-1:0]          dcnt_q, dcnt_d;
  logic [AccW-1:0]          acc_q, acc_d;
  logic [AccW-1:0]          hold1_q, hold1_d;
  logic [7:0]               hold2_q, hold2_d;
  logic [7:0]               face_q, face_d;
  logic [23:0]              colour_q, colour_d;
  logic                     blink_q, blink_d;
  logic [POSITION_BITS-1:0] count_q, count_d;
  logic                     moved_q, moved_d;
  logic                     start_q, start_d;

  logic [7:0]      face_cur;
  logic [23:0]     colour_cur;
  logic            is_digit;
  logic [3:0]      dig;
  logic [12:0]     acc_mul;
  logic [AccW-1:0] acc_new;
  logic [CntW-1:0] cnt_new;
  logic            num_pend;
  logic            fresh;
  logic            is_char;
  logic            is_move;
  logic            is_align;
  logic [31:0]     count_ext;

  assign face_cur   = start_q ? cfg_i.face : face_q;
  assign colour_cur = start_q ? {cfg_i.red, cfg_i.green, cfg_i.blue} : colour_q;

  assign is_digit = char_i inside {[CH_0:CH_9]};
  assign dig      = 4'(char_i - CH_0);
  // acc * 10 + digit, kept to the accumulator width
  assign acc_mul  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + 13'(dig);
  assign acc_new  = acc_mul[AccW-1:0];
  assign cnt_new  = dcnt_q + 1'b1;

  assign num_pend = inside_q && (pend_q == PD_COLOUR || pend_q == PD_MOVE);
  // byte is read as a new directive: nothing pending, or a failed number
  assign fresh    = inside_q && ((pend_q == PD_NONE) || (num_pend && !is_digit));

  assign is_char  = !inside_q && !(char_i inside {CH_LBRACE, CH_LBRACK, CH_RBRACK});
  assign is_move  = num_pend && is_digit && pend_q == PD_MOVE && cnt_new == CntSecond;
  assign is_align = fresh && (char_i inside {CH_LEFT, CH_RIGHT, CH_CENTER, CH_JUST});

  assign count_ext = 32'(count_q);

  // next parse state
  always_comb begin
    inside_d = inside_q;
    pend_d   = pend_q;
    dcnt_d   = dcnt_q;
    acc_d    = acc_q;
    hold1_d  = hold1_q;
    hold2_d  = hold2_q;
    face_d   = face_cur;
    colour_d = colour_cur;
    blink_d  = blink_q;
    count_d  = count_q;
    moved_d  = moved_q;
    start_d  = 1'b0;

    if (inside_q) begin
      case (pend_q)
        PD_FACE: begin
          face_d = char_i;
          pend_d = PD_NONE;
        end
        PD_SKIP: pend_d = PD_NONE;
        PD_COLOUR, PD_MOVE: begin
          if (!is_digit) begin
            pend_d = PD_NONE;
            dcnt_d = '0;
            acc_d  = '0;
          end else if (cnt_new == CntFirst) begin
            hold1_d = acc_new;
            acc_d   = '0;
            dcnt_d  = cnt_new;
          end else if (cnt_new == CntSecond && pend_q == PD_COLOUR) begin
            hold2_d = acc_new[7:0];
            acc_d   = '0;
            dcnt_d  = cnt_new;
          end else if (cnt_new == CntSecond) begin
            moved_d = 1'b1;
            pend_d  = PD_NONE;
            dcnt_d  = '0;
            acc_d   = '0;
          end else if (cnt_new >= CntLast) begin
            colour_d = {hold1_q[7:0], hold2_q, acc_new[7:0]};
            pend_d   = PD_NONE;
            dcnt_d   = '0;
            acc_d    = '0;
          end else begin
            acc_d  = acc_new;
            dcnt_d = cnt_new;
          end
        end
        default: pend_d = PD_NONE;
      endcase

      if (fresh) begin
        case (char_i)
          CH_RBRACE: inside_d = 1'b0;
          CH_FACE:   pend_d = PD_FACE;
          CH_SKIP:   pend_d = PD_SKIP;
          CH_COLOUR: begin
            pend_d = PD_COLOUR;
            dcnt_d = '0;
            acc_d  = '0;
          end
          CH_MOVE: begin
            pend_d = PD_MOVE;
            dcnt_d = '0;
            acc_d  = '0;
          end
          CH_BLINK:  blink_d = 1'b1;
          default:   ;
        endcase
      end
    end else if (char_i == CH_LBRACE) begin
      inside_d = 1'b1;
      pend_d   = PD_NONE;
    end else if (is_char && count_q != CountMax) begin
      count_d = count_q + 1'b1;
    end

    if (last_i) begin
      inside_d = 1'b0;
      pend_d   = PD_NONE;
      dcnt_d   = '0;
      acc_d    = '0;
      hold1_d  = '0;
      hold2_d  = '0;
      blink_d  = 1'b0;
      count_d  = '0;
      moved_d  = 1'b0;
      start_d  = 1'b1;
    end
  end

  // result of this byte
  always_comb begin
    res_valid_o = is_char || is_move || is_align;
    res_o       = '0;
    if (is_char) begin
      res_o.kind        = KIND_CHAR;
      res_o.glyph_code  = char_i;
      res_o.face_letter = face_cur;
      res_o.red         = colour_cur[23:16];
      res_o.green       = colour_cur[15:8];
      res_o.blue        = colour_cur[7:0];
      res_o.blinking    = blink_q;
    end else if (is_move) begin
      res_o.kind         = KIND_MOVE;
      res_o.run_position = count_ext[PosOutW-1:0];
      res_o.x_percent    = hold1_q;
      res_o.y_percent    = acc_new;
    end else if (is_align) begin
      res_o.kind            = KIND_ALIGN;
      res_o.applies_to_move = moved_q;
      case (char_i)
        CH_LEFT:   res_o.align_code = ALIGN_LEFT;
        CH_RIGHT:  res_o.align_code = ALIGN_RIGHT;
        CH_CENTER: res_o.align_code = ALIGN_CENTER;
        default:   res_o.align_code = ALIGN_JUSTIFY;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      pend_q   <= PD_NONE;
      dcnt_q   <= '0;
      acc_q    <= '0;
      hold1_q  <= '0;
      hold2_q  <= '0;
      face_q   <= '0;
      colour_q <= '1;
      blink_q  <= 1'b0;
      count_q  <= '0;
      moved_q  <= 1'b0;
      start_q  <= 1'b1;
    end else if (step_i) begin
      inside_q <= inside_d;
      pend_q   <= pend_d;
      dcnt_q   <= dcnt_d;
      acc_q    <= acc_d;
      hold1_q  <= hold1_d;
      hold2_q  <= hold2_d;
      face_q   <= face_d;
      colour_q <= colour_d;
      blink_q  <= blink_d;
      count_q  <= count_d;
      moved_q  <= moved_d;
      start_q  <= start_d;
    end
  end

endmodule
